### hdl/pnss_pkg.sv
// ----------------------------------------------------------------------------
// pnss_pkg
// Types and constants shared by the polyline snap block.
// ----------------------------------------------------------------------------
package pnss_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int MW    = 27;          // multiplier operand width (signed)
    localparam int PW    = 2 * MW;      // product / accumulator width
    localparam int SQ_W  = PW;          // root unit input width
    localparam int RT_W  = SQ_W / 2;    // root width
    localparam int QF    = 16;          // projection fraction bits

    localparam logic [24:0] DIST_NONE = 25'h1FFFFFF;
    localparam logic [24:0] DIST_SAT  = 25'h1FFFFFE;
    localparam logic [27:0] ALONG_MAX = 28'hFFFFFFF;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FROM  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [9:0]         from_index;
        logic [9:0]         to_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [24:0] nearest_distance;
        logic [9:0]  segment_index;
        logic [27:0] along_distance;
        logic [10:0] stored_points;
    } t_out_item;

    typedef struct packed {
        t_cmd     kind;
        t_in_item item;
    } t_job;

endpackage

### hdl/polyline_nearest_segment_snap_top.sv
// ----------------------------------------------------------------------------
// polyline_nearest_segment_snap_top
// Polyline store with course length and windowed nearest-segment snap.
// ----------------------------------------------------------------------------
// Clear and unused commands go straight to the result. The first append is
// written at once; later appends take a 27-step root of the segment length.
// A query ends early if from is past the count or the window is empty. Each
// segment may run the divider; a new nearest also takes a root of its length.
// One item is worked at a time; a two-beat queue takes input meanwhile.
// Reset empties the store (count zero) and the queue; point memories keep data.
// ----------------------------------------------------------------------------
module polyline_nearest_segment_snap_top import pnss_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic job_valid;
    logic job_pop;
    t_job job;

    pnss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    pnss_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### hdl/pnss_ram.sv
// ----------------------------------------------------------------------------
// pnss_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pnss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

### hdl/pnss_isqrt.sv
// ----------------------------------------------------------------------------
// pnss_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pnss_isqrt import pnss_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_val,
    output logic            o_done,
    output logic [RT_W-1:0] o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[RT_W-1:0];

endmodule

### hdl/pnss_div.sv
// ----------------------------------------------------------------------------
// pnss_div
// Restoring divider giving the QF-bit fraction of num/den, num < den.
// ----------------------------------------------------------------------------
module pnss_div import pnss_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_num,
    input  logic [PW-1:0] i_den,
    output logic          o_done,
    output logic [QF-1:0] o_quo
);

    logic                   r_busy;
    logic                   r_done;
    logic [$clog2(QF)-1:0]  r_cnt;
    logic [PW:0]            r_rem;
    logic [PW-1:0]          r_den;
    logic [QF-1:0]          r_q;
    logic [PW:0]            sh;

    assign sh = {r_rem[PW-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(QF)'(QF - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                r_rem <= sh - {1'b0, r_den};
                r_q   <= {r_q[QF-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q   <= {r_q[QF-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

### hdl/pnss_front.sv
// ----------------------------------------------------------------------------
// pnss_front
// Input beat acceptance, command decode and a two-entry job queue.
// ----------------------------------------------------------------------------
module pnss_front import pnss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_pop
);

    localparam int QD = 2;

    t_job       r_q [QD];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_job       job_in;

    always_comb begin
        job_in.item = i_in_data;
        case (i_in_data.cmd)
            CMD_CLEAR:  job_in.kind = CMD_CLEAR;
            CMD_APPEND: job_in.kind = CMD_APPEND;
            CMD_QUERY:  job_in.kind = CMD_QUERY;
            default:    job_in.kind = CMD_NONE;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'(QD));
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_job_pop && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

### hdl/pnss_back.sv
// ----------------------------------------------------------------------------
// pnss_back
// Point store and command sequencer: append with course length, windowed
// nearest-segment search, result register.
// ----------------------------------------------------------------------------
module pnss_back import pnss_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (CW > 11) ? CW : 11;

    typedef enum logic [29:0] {
        S_IDLE    = 30'b1 << 0,
        S_A_DIFF  = 30'b1 << 1,
        S_A_M1    = 30'b1 << 2,
        S_A_M2    = 30'b1 << 3,
        S_A_SQ    = 30'b1 << 4,
        S_A_SQW   = 30'b1 << 5,
        S_A_WR    = 30'b1 << 6,
        S_Q_RD0   = 30'b1 << 7,
        S_Q_LA    = 30'b1 << 8,
        S_Q_LB    = 30'b1 << 9,
        S_G_DIFF  = 30'b1 << 10,
        S_G_M1    = 30'b1 << 11,
        S_G_M2    = 30'b1 << 12,
        S_G_M3    = 30'b1 << 13,
        S_G_M4    = 30'b1 << 14,
        S_G_DIV   = 30'b1 << 15,
        S_G_DIVW  = 30'b1 << 16,
        S_G_OFX   = 30'b1 << 17,
        S_G_OFY   = 30'b1 << 18,
        S_G_EX    = 30'b1 << 19,
        S_G_SQ1   = 30'b1 << 20,
        S_G_SQ2   = 30'b1 << 21,
        S_G_CMP   = 30'b1 << 22,
        S_G_LEN   = 30'b1 << 23,
        S_G_LENW  = 30'b1 << 24,
        S_G_ALONG = 30'b1 << 25,
        S_G_NEXT  = 30'b1 << 26,
        S_F_SQ    = 30'b1 << 27,
        S_F_SQW   = 30'b1 << 28,
        S_DONE    = 30'b1 << 29
    } t_state;

    t_state    r_state;
    logic [CW-1:0] r_count;
    t_in_item  r_item;
    t_out_item r_res;
    t_out_item r_out;
    logic      r_oval;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_end;
    logic signed [23:0] r_ax, r_ay, r_bx, r_by;
    logic signed [23:0] r_last_x, r_last_y;
    logic [27:0] r_last_cum, r_cum_a, r_cum_b;
    logic signed [MW-1:0] r_dx, r_dy, r_rx, r_ry, r_ex, r_ey;
    logic [PW-1:0] r_len2, r_prod, r_d2, r_best;
    logic signed [PW-1:0] r_dot;
    logic [QF:0]   r_t;
    logic [RT_W-1:0] r_seglen;
    logic          r_found;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic [PW-1:0] rnd_w, al_sum;
    logic [MW-1:0] off_m;
    logic [28:0]   app_sum;
    logic [IW-1:0] from_w, to_w, cnt_w, cm1, ip1, ip2;
    logic [AW-1:0] rd_addr;
    logic [23:0]   x_rd, y_rd;
    logic [27:0]   c_rd;
    logic          ram_we;
    logic          sq_start, sq_done, dv_start, dv_done;
    logic [SQ_W-1:0] sq_in;
    logic [RT_W-1:0] sq_root;
    logic [QF-1:0] dv_quo;
    logic          out_take;
    logic          out_load;

    assign from_w = IW'(r_item.from_index);
    assign to_w   = IW'(r_item.to_index);
    assign cnt_w  = IW'(r_count);
    assign cm1    = cnt_w - IW'(1);
    assign ip1    = r_i + IW'(1);
    assign ip2    = r_i + IW'(2);

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign out_take  = r_oval && !i_out_stall;
    assign out_load  = (r_state == S_DONE) && (!r_oval || !i_out_stall);
    assign ram_we    = (r_state == S_A_WR);

    assign sq_start = (r_state == S_A_SQ) || (r_state == S_G_LEN) || (r_state == S_F_SQ);
    assign sq_in    = (r_state == S_F_SQ) ? r_best : r_len2;
    assign dv_start = (r_state == S_G_DIV) && !r_dot[PW-1] && (r_dot != '0)
                      && (r_len2 != '0) && (PW'(r_dot) < r_len2);

    // shared multiplier, operands picked by the sequencer step
    always_comb begin
        case (r_state)
            S_A_M1, S_G_M1: begin mul_a = r_dx; mul_b = r_dx; end
            S_A_M2, S_G_M2: begin mul_a = r_dy; mul_b = r_dy; end
            S_G_M3:  begin mul_a = r_rx; mul_b = r_dx; end
            S_G_M4:  begin mul_a = r_ry; mul_b = r_dy; end
            S_G_OFX: begin
                mul_a = r_dx[MW-1] ? -r_dx : r_dx;
                mul_b = $signed(MW'(r_t));
            end
            S_G_OFY: begin
                mul_a = r_dy[MW-1] ? -r_dy : r_dy;
                mul_b = $signed(MW'(r_t));
            end
            S_G_SQ1: begin mul_a = r_ex; mul_b = r_ex; end
            S_G_SQ2: begin mul_a = r_ey; mul_b = r_ey; end
            S_G_ALONG: begin
                mul_a = $signed(MW'(r_seglen));
                mul_b = $signed(MW'(r_t));
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign rnd_w   = (r_prod + PW'(32768)) >> QF;
    assign off_m   = rnd_w[MW-1:0];
    assign al_sum  = PW'(r_cum_a) + ((PW'(mul_p) + PW'(32768)) >> QF);
    assign app_sum = 29'(r_last_cum) + 29'(r_seglen);

    always_comb begin
        case (r_state)
            S_Q_RD0:  rd_addr = from_w[AW-1:0];
            S_Q_LA:   rd_addr = ip1[AW-1:0];
            S_G_NEXT: rd_addr = ip2[AW-1:0];
            default:  rd_addr = '0;
        endcase
    end

    pnss_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_item.pos_x), .i_raddr(rd_addr), .o_rdata(x_rd)
    );

    pnss_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_item.pos_y), .i_raddr(rd_addr), .o_rdata(y_rd)
    );

    pnss_ram #(.WIDTH(28), .DEPTH(MAX_POINTS)) u_ram_c (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_count[AW-1:0]),
        .i_wdata((r_count == '0) ? 28'd0 :
                 (app_sum > 29'(ALONG_MAX)) ? ALONG_MAX : app_sum[27:0]),
        .i_raddr(rd_addr), .o_rdata(c_rd)
    );

    pnss_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(sq_in),
        .o_done(sq_done), .o_root(sq_root)
    );

    pnss_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(PW'(r_dot)), .i_den(r_len2), .o_done(dv_done), .o_quo(dv_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (out_take) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_item                 <= i_job.item;
                        r_res.status           <= (i_job.kind == CMD_APPEND &&
                                                   r_count == CW'(MAX_POINTS)) ? ST_FULL
                                                                               : ST_OK;
                        r_res.nearest_distance <= '0;
                        r_res.segment_index    <= '0;
                        r_res.along_distance   <= '0;
                        r_res.stored_points    <= '0;
                        r_found                <= 1'b0;
                        case (i_job.kind)
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            CMD_APPEND: begin
                                if (r_count == CW'(MAX_POINTS)) begin
                                    r_state <= S_DONE;
                                end else if (r_count == '0) begin
                                    r_state <= S_A_WR;
                                end else begin
                                    r_state <= S_A_DIFF;
                                end
                            end
                            CMD_QUERY: r_state <= S_Q_RD0;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_A_DIFF: begin
                    r_dx    <= MW'(r_item.pos_x) - MW'(r_last_x);
                    r_dy    <= MW'(r_item.pos_y) - MW'(r_last_y);
                    r_state <= S_A_M1;
                end
                S_A_M1: begin
                    r_len2  <= PW'(mul_p);
                    r_state <= S_A_M2;
                end
                S_A_M2: begin
                    r_len2  <= r_len2 + PW'(mul_p);
                    r_state <= S_A_SQ;
                end
                S_A_SQ: r_state <= S_A_SQW;
                S_A_SQW: begin
                    if (sq_done) begin
                        r_seglen <= sq_root;
                        r_state  <= S_A_WR;
                    end
                end
                S_A_WR: begin
                    r_last_x   <= r_item.pos_x;
                    r_last_y   <= r_item.pos_y;
                    r_last_cum <= (r_count == '0) ? 28'd0 :
                                  (app_sum > 29'(ALONG_MAX)) ? ALONG_MAX : app_sum[27:0];
                    r_count    <= r_count + CW'(1);
                    r_state    <= S_DONE;
                end
                S_Q_RD0: begin
                    r_res.segment_index <= r_item.from_index;
                    r_i                 <= from_w;
                    r_end               <= (to_w < cm1) ? to_w : cm1;
                    if (r_count == '0 || from_w >= cnt_w) begin
                        r_res.status           <= ST_FROM;
                        r_res.nearest_distance <= DIST_NONE;
                        r_state                <= S_DONE;
                    end else begin
                        r_state <= S_Q_LA;
                    end
                end
                S_Q_LA: begin
                    r_ax                 <= $signed(x_rd);
                    r_ay                 <= $signed(y_rd);
                    r_cum_a              <= c_rd;
                    r_res.along_distance <= c_rd;
                    if (r_i >= r_end) begin
                        r_res.status           <= ST_EMPTY;
                        r_res.nearest_distance <= DIST_NONE;
                        r_state                <= S_DONE;
                    end else begin
                        r_state <= S_Q_LB;
                    end
                end
                S_Q_LB: begin
                    r_bx    <= $signed(x_rd);
                    r_by    <= $signed(y_rd);
                    r_cum_b <= c_rd;
                    r_state <= S_G_DIFF;
                end
                S_G_DIFF: begin
                    r_dx    <= MW'(r_bx) - MW'(r_ax);
                    r_dy    <= MW'(r_by) - MW'(r_ay);
                    r_rx    <= MW'(r_item.pos_x) - MW'(r_ax);
                    r_ry    <= MW'(r_item.pos_y) - MW'(r_ay);
                    r_state <= S_G_M1;
                end
                S_G_M1: begin
                    r_len2  <= PW'(mul_p);
                    r_state <= S_G_M2;
                end
                S_G_M2: begin
                    r_len2  <= r_len2 + PW'(mul_p);
                    r_state <= S_G_M3;
                end
                S_G_M3: begin
                    r_dot   <= mul_p;
                    r_state <= S_G_M4;
                end
                S_G_M4: begin
                    r_dot   <= r_dot + mul_p;
                    r_state <= S_G_DIV;
                end
                S_G_DIV: begin
                    // degenerate segment or point behind start: t = 0
                    if (r_len2 == '0 || r_dot[PW-1] || r_dot == '0) begin
                        r_t     <= '0;
                        r_state <= S_G_OFX;
                    end else if (PW'(r_dot) >= r_len2) begin
                        r_t     <= {1'b1, {QF{1'b0}}};
                        r_state <= S_G_OFX;
                    end else begin
                        r_state <= S_G_DIVW;
                    end
                end
                S_G_DIVW: begin
                    if (dv_done) begin
                        r_t     <= {1'b0, dv_quo};
                        r_state <= S_G_OFX;
                    end
                end
                S_G_OFX: begin
                    r_prod  <= PW'(mul_p);
                    r_state <= S_G_OFY;
                end
                S_G_OFY: begin
                    r_ex    <= r_dx[MW-1] ? r_rx + $signed(off_m) : r_rx - $signed(off_m);
                    r_prod  <= PW'(mul_p);
                    r_state <= S_G_EX;
                end
                S_G_EX: begin
                    r_ey    <= r_dy[MW-1] ? r_ry + $signed(off_m) : r_ry - $signed(off_m);
                    r_state <= S_G_SQ1;
                end
                S_G_SQ1: begin
                    r_d2    <= PW'(mul_p);
                    r_state <= S_G_SQ2;
                end
                S_G_SQ2: begin
                    r_d2    <= r_d2 + PW'(mul_p);
                    r_state <= S_G_CMP;
                end
                S_G_CMP: begin
                    r_state <= (!r_found || r_d2 < r_best) ? S_G_LEN : S_G_NEXT;
                end
                S_G_LEN: r_state <= S_G_LENW;
                S_G_LENW: begin
                    if (sq_done) begin
                        r_seglen <= sq_root;
                        r_state  <= S_G_ALONG;
                    end
                end
                S_G_ALONG: begin
                    r_found              <= 1'b1;
                    r_best               <= r_d2;
                    r_res.segment_index  <= r_i[9:0];
                    r_res.along_distance <= (al_sum > PW'(ALONG_MAX)) ? ALONG_MAX
                                                                      : al_sum[27:0];
                    r_state              <= S_G_NEXT;
                end
                S_G_NEXT: begin
                    if (ip1 < r_end) begin
                        r_ax    <= r_bx;
                        r_ay    <= r_by;
                        r_cum_a <= r_cum_b;
                        r_i     <= ip1;
                        r_state <= S_Q_LB;
                    end else begin
                        r_state <= S_F_SQ;
                    end
                end
                S_F_SQ: r_state <= S_F_SQW;
                S_F_SQW: begin
                    if (sq_done) begin
                        r_res.nearest_distance <= (sq_root > RT_W'(DIST_SAT)) ? DIST_SAT
                                                                              : sq_root[24:0];
                        r_state                <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out   <= t_out_item'({r_res.status, r_res.nearest_distance,
                                                r_res.segment_index, r_res.along_distance,
                                                11'(r_count)});
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IW'(r_count) <= IW'(MAX_POINTS))
        else $error("point count above capacity");

    a_from_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_out.status == ST_FROM) |-> r_out.nearest_distance == DIST_NONE)
        else $error("from-beyond-count result without none distance");

    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_G_DIFF) |-> (r_i < r_end))
        else $error("segment walk left the window");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && i_out_stall) |=> (r_oval && $stable(r_out)))
        else $error("result register changed while stalled");

endmodule
